>>> rtl/mce_pkg.sv
// Package for the Monte Carlo mean estimator.
// Holds the register indexes, register widths, reset values and arithmetic unit opcodes.
// No dependencies.
package mce_pkg;

	localparam int COUNT_BITS_DEF = 32;
	localparam int CFG_DATA_W     = 48;
	localparam int CFG_INDEX_W    = 2;
	localparam int FRAC_BITS      = 16;
	localparam int EST_W          = 17;
	localparam int STATUS_W       = 2;
	localparam int TOTAL_W        = 32;
	localparam int TOL_W          = 16;
	localparam int TARGET_W       = 32;

	localparam logic [TARGET_W-1:0]   SUCCESS_TARGET_RST = 32'd100;
	localparam logic [CFG_DATA_W-1:0] PAIR_SCALE_RST     = 48'd65536;
	localparam logic [CFG_DATA_W-1:0] FINAL_SCALE_RST    = 48'd65536;
	localparam logic [TOL_W-1:0]      TOLERANCE_RST      = 16'd6554;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SUCCESS_TARGET = 2'd0,
		REG_PAIR_SCALE     = 2'd1,
		REG_FINAL_SCALE    = 2'd2,
		REG_TOLERANCE      = 2'd3
	} reg_index_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_SAT   = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_MUL_NUM = 2'd1,
		OP_MUL_DEN = 2'd2,
		OP_DIV     = 2'd3
	} unit_op_t;

endpackage

>>> rtl/mce_unit.sv
// Shared multiply and divide unit of the mean estimator.
// Shift-add multiply one multiplier bit a cycle, restoring divide one quotient bit a cycle.
// Depends on mce_pkg.
module mce_unit #(
	parameter int W  = 144,
	parameter int MW = 33
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mce_pkg::unit_op_t op,
	input  logic [W-1:0]      opa,
	input  logic [W-1:0]      opb,
	input  logic [MW-1:0]     opm,
	output logic [W-1:0]      quo,
	output logic              rem_nz,
	output logic              done
);
	import mce_pkg::*;

	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  num_q, den_q, acc_q, x_q;
	logic [MW-1:0] m_q;
	logic [W:0]    rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q, done_q;
	unit_op_t      op_q;

	logic [W-1:0] acc_n;
	logic [W:0]   trial;
	logic         ge;

	assign acc_n = m_q[0] ? acc_q + x_q : acc_q;
	assign trial = {rem_q[W-1:0], num_q[W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= OP_LOAD;
			cnt_q  <= '0;
		end else begin
			// A load finishes at once; the others finish on their last busy cycle.
			done_q <= start ? (op == OP_LOAD) : (busy_q && cnt_q == CW'(1));
			if (start) begin
				op_q <= op;
				unique case (op)
					OP_LOAD: ;
					OP_MUL_NUM, OP_MUL_DEN: begin
						busy_q <= 1'b1;
						cnt_q  <= CW'(MW);
					end
					OP_DIV: begin
						busy_q <= 1'b1;
						cnt_q  <= CW'(W);
					end
					default: ;
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			unique case (op)
				OP_LOAD: begin
					num_q <= opa;
					den_q <= opb;
				end
				OP_MUL_NUM: begin
					x_q   <= num_q;
					acc_q <= '0;
					m_q   <= opm;
				end
				OP_MUL_DEN: begin
					x_q   <= den_q;
					acc_q <= '0;
					m_q   <= opm;
				end
				OP_DIV: begin
					rem_q <= '0;
				end
				default: ;
			endcase
		end else if (busy_q) begin
			unique case (op_q)
				OP_MUL_NUM, OP_MUL_DEN: begin
					acc_q <= acc_n;
					x_q   <= {x_q[W-2:0], 1'b0};
					m_q   <= {1'b0, m_q[MW-1:1]};
					if (cnt_q == CW'(1)) begin
						if (op_q == OP_MUL_NUM)
							num_q <= acc_n;
						else
							den_q <= acc_n;
					end
				end
				OP_DIV: begin
					rem_q <= ge ? trial - {1'b0, den_q} : trial;
					num_q <= {num_q[W-2:0], ge};
				end
				default: ;
			endcase
		end
	end

	assign quo    = num_q;
	assign rem_nz = |rem_q;
	assign done   = done_q;

endmodule

>>> rtl/monte_carlo_mean_estimator.sv
// Top level of the Monte Carlo mean estimator: sample counters, sequencer, output register.
// Instantiates mce_unit; depends on mce_pkg.
//
// Channel   Dir  Handshake           Contents
// s_*       in   s_tvalid/s_tready   tdata[0] = sample
// m_*       out  m_tvalid/m_tready   tdata: estimate[16:0], status[18:17], total_samples[50:19]
// cfg_*     in   cfg_we              cfg_index selects the register, cfg_data the value
//
// In the three sampling phases every item is taken in one cycle. The shared unit then
// computes the pair target (load, multiply, divide, store); the final target (load, six
// multiplies, divide, store), which goes straight to its store when there are no pairs;
// and the estimate (load, divide, output). s_tready is low throughout these steps.
// The result waits in an output register while the next run starts; a later result stalls
// only if that register is still full. Reset clears all counters.
module monte_carlo_mean_estimator #(
	parameter int COUNT_BITS = mce_pkg::COUNT_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [7:0]                       s_tdata,   // [0] sample
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [55:0]                      m_tdata,   // [16:0] estimate, [18:17] status,
	                                                    // [50:19] total_samples
	input  logic                             cfg_we,
	input  logic [mce_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [mce_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import mce_pkg::*;

	localparam int CB = COUNT_BITS;
	// Widest numerator: final_scale * alternations * c1 * c1.
	localparam int W  = CFG_DATA_W + 3 * CB;
	localparam int MW = CB + 1;
	localparam logic [CB-1:0] CMAX = '1;

	typedef enum logic [18:0] {
		ST_P1        = 19'h00001,
		ST_P2        = 19'h00002,
		ST_P3        = 19'h00004,
		ST_PT_LOAD   = 19'h00008,
		ST_PT_MUL    = 19'h00010,
		ST_PT_DIV    = 19'h00020,
		ST_PT_END    = 19'h00040,
		ST_FT_LOAD   = 19'h00080,
		ST_FT_MUL_A  = 19'h00100,
		ST_FT_MUL_C1 = 19'h00200,
		ST_FT_MUL_C2 = 19'h00400,
		ST_FT_MUL_S1 = 19'h00800,
		ST_FT_MUL_S2 = 19'h01000,
		ST_FT_MUL_K  = 19'h02000,
		ST_FT_DIV    = 19'h04000,
		ST_FT_END    = 19'h08000,
		ST_ES_LOAD   = 19'h10000,
		ST_ES_DIV    = 19'h20000,
		ST_ES_OUT    = 19'h40000
	} state_t;

	// Configuration registers.
	logic [TARGET_W-1:0]   success_target_q;
	logic [CFG_DATA_W-1:0] pair_scale_q, final_scale_q;
	logic [TOL_W-1:0]      tolerance_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			success_target_q <= SUCCESS_TARGET_RST;
			pair_scale_q     <= PAIR_SCALE_RST;
			final_scale_q    <= FINAL_SCALE_RST;
			tolerance_q      <= TOLERANCE_RST;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_SUCCESS_TARGET: success_target_q <= cfg_data[TARGET_W-1:0];
				REG_PAIR_SCALE:     pair_scale_q     <= cfg_data;
				REG_FINAL_SCALE:    final_scale_q    <= cfg_data;
				REG_TOLERANCE:      tolerance_q      <= cfg_data[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	state_t        state_q;
	logic          issued_q, sat_q, empty_q, first_q;
	logic [CB-1:0] c1_q, s1_q, pt_q, ps_q, alt_q, ft_q, fsamp_q, fsucc_q, ta_q;
	logic          m_valid_q;
	logic [55:0]   m_data_q;

	// Shared unit hookup.
	logic          u_start, u_rem_nz, u_done;
	unit_op_t      u_op;
	logic [W-1:0]  u_opa, u_opb, u_quo;
	logic [MW-1:0] u_opm;
	logic          computing;

	mce_unit #(.W(W), .MW(MW)) u_unit (
		.clk(clk), .arst_n(arst_n), .start(u_start), .op(u_op),
		.opa(u_opa), .opb(u_opb), .opm(u_opm),
		.quo(u_quo), .rem_nz(u_rem_nz), .done(u_done)
	);

	assign computing = !(state_q == ST_P1 || state_q == ST_P2 || state_q == ST_P3
	                     || state_q == ST_PT_END || state_q == ST_FT_END
	                     || state_q == ST_ES_OUT);
	assign u_start   = computing && !issued_q;

	always_comb begin
		u_op  = OP_LOAD;
		u_opa = '0;
		u_opb = '0;
		u_opm = '0;
		unique case (state_q)
			ST_PT_LOAD: begin
				u_opa = W'(pair_scale_q);
				u_opb = {{(W-CB-FRAC_BITS){1'b0}}, s1_q, {FRAC_BITS{1'b0}}};
			end
			ST_PT_MUL: begin
				u_op  = OP_MUL_NUM;
				u_opm = MW'(c1_q);
			end
			ST_FT_LOAD: begin
				u_opa = W'(final_scale_q);
				u_opb = W'(pt_q);
			end
			ST_FT_MUL_A: begin
				u_op  = OP_MUL_NUM;
				u_opm = MW'(alt_q);
			end
			ST_FT_MUL_C1, ST_FT_MUL_C2: begin
				u_op  = OP_MUL_NUM;
				u_opm = MW'(c1_q);
			end
			ST_FT_MUL_S1, ST_FT_MUL_S2: begin
				u_op  = OP_MUL_DEN;
				u_opm = MW'(s1_q);
			end
			ST_FT_MUL_K: begin
				// Multiply the denominator by 65536.
				u_op  = OP_MUL_DEN;
				u_opm = MW'(1) << FRAC_BITS;
			end
			ST_ES_LOAD: begin
				u_opa = {{(W-CB-FRAC_BITS){1'b0}}, fsucc_q, {FRAC_BITS{1'b0}}};
				u_opb = W'(ft_q);
			end
			ST_PT_DIV, ST_FT_DIV, ST_ES_DIV: u_op = OP_DIV;
			default: ;
		endcase
	end

	// Phase-one goal: zero acts as one, anything above the counter range as its maximum.
	logic [TARGET_W-1:0] goal_raw;
	logic [CB-1:0]       goal;
	always_comb begin
		goal_raw = (success_target_q == '0) ? TARGET_W'(1) : success_target_q;
		if (CB < TARGET_W && (goal_raw >> CB) != '0)
			goal = CMAX;
		else
			goal = CB'(goal_raw);
	end

	// Saturating counter steps; the flag comes from any counter already at its top.
	logic [CB-1:0] c1_n, s1_n, ps_n, alt_n, fsamp_n, fsucc_n;
	logic          bit_in, acc_in, sat_step, pair_second;
	assign bit_in      = s_tdata[0];
	assign acc_in      = s_tvalid && s_tready;
	assign pair_second = ps_q[0];

	always_comb begin
		c1_n     = c1_q;
		s1_n     = s1_q;
		ps_n     = ps_q;
		alt_n    = alt_q;
		fsamp_n  = fsamp_q;
		fsucc_n  = fsucc_q;
		sat_step = 1'b0;
		unique case (state_q)
			ST_P1: begin
				if (c1_q == CMAX) sat_step = 1'b1; else c1_n = c1_q + 1'b1;
				if (bit_in) begin
					if (s1_q == CMAX) sat_step = 1'b1; else s1_n = s1_q + 1'b1;
				end
			end
			ST_P2: begin
				if (ps_q == CMAX) sat_step = 1'b1; else ps_n = ps_q + 1'b1;
				if (pair_second && first_q != bit_in) begin
					if (alt_q == CMAX) sat_step = 1'b1; else alt_n = alt_q + 1'b1;
				end
			end
			ST_P3: begin
				if (fsamp_q == CMAX) sat_step = 1'b1; else fsamp_n = fsamp_q + 1'b1;
				if (bit_in) begin
					if (fsucc_q == CMAX) sat_step = 1'b1; else fsucc_n = fsucc_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Quotient clamping for the pair target (rounded up) and term A (rounded down).
	logic          q_hi, pt_sat, ta_sat;
	logic [CB-1:0] pt_val, ta_val;
	assign q_hi   = |u_quo[W-1:CB];
	assign pt_sat = q_hi || (u_quo[CB-1:0] == CMAX && u_rem_nz);
	assign pt_val = pt_sat ? CMAX : u_quo[CB-1:0] + CB'(u_rem_nz);
	assign ta_sat = q_hi;
	assign ta_val = q_hi ? CMAX : u_quo[CB-1:0];

	// Term B = final_scale * tolerance / 2^32, then the larger term wins.
	logic [CFG_DATA_W+TOL_W-1:0] tb_prod;
	logic [W-1:0]                tb_wide;
	logic                        tb_sat;
	logic [CB-1:0]               tb_val, ft_val;
	assign tb_prod = final_scale_q * tolerance_q;
	assign tb_wide = W'(tb_prod[CFG_DATA_W+TOL_W-1:32]);
	assign tb_sat  = |tb_wide[W-1:CB];
	assign tb_val  = tb_sat ? CMAX : tb_wide[CB-1:0];
	assign ft_val  = (ta_q > tb_val) ? ta_q : tb_val;

	// Result fields.
	logic [63:0]          total_w;
	logic [TOTAL_W-1:0]   total;
	logic [EST_W-1:0]     est;
	status_t              stat;
	logic                 out_free;
	assign total_w  = 64'(c1_q) + 64'(ps_q) + 64'(fsamp_q);
	assign total    = (|total_w[63:TOTAL_W]) ? '1 : total_w[TOTAL_W-1:0];
	assign est      = empty_q ? '0 : u_quo[EST_W-1:0];
	assign stat     = empty_q ? STAT_EMPTY : (sat_q ? STAT_SAT : STAT_OK);
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_P1;
			issued_q  <= 1'b0;
			sat_q     <= 1'b0;
			empty_q   <= 1'b0;
			first_q   <= 1'b0;
			c1_q      <= '0;
			s1_q      <= '0;
			pt_q      <= '0;
			ps_q      <= '0;
			alt_q     <= '0;
			ft_q      <= '0;
			fsamp_q   <= '0;
			fsucc_q   <= '0;
			ta_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			// In the output state the register is refilled below instead.
			if (m_valid_q && m_tready && state_q != ST_ES_OUT)
				m_valid_q <= 1'b0;
			if (u_start)
				issued_q <= 1'b1;
			if (u_done)
				issued_q <= 1'b0;
			if (acc_in) begin
				c1_q    <= c1_n;
				s1_q    <= s1_n;
				ps_q    <= ps_n;
				alt_q   <= alt_n;
				fsamp_q <= fsamp_n;
				fsucc_q <= fsucc_n;
				if (sat_step)
					sat_q <= 1'b1;
				if (state_q == ST_P2 && !pair_second)
					first_q <= bit_in;
			end
			unique case (state_q)
				ST_P1: if (acc_in && s1_n >= goal) state_q <= ST_PT_LOAD;
				ST_P2: if (acc_in && pair_second && ps_n >= pt_q) state_q <= ST_FT_LOAD;
				ST_P3: if (acc_in && fsamp_n >= ft_q) state_q <= ST_ES_LOAD;
				ST_PT_LOAD:   if (u_done) state_q <= ST_PT_MUL;
				ST_PT_MUL:    if (u_done) state_q <= ST_PT_DIV;
				ST_PT_DIV:    if (u_done) state_q <= ST_PT_END;
				ST_PT_END: begin
					pt_q <= pt_val;
					if (pt_sat)
						sat_q <= 1'b1;
					if (pt_val == '0) begin
						// No pairs: the alternation term is zero.
						ta_q    <= '0;
						state_q <= ST_FT_END;
					end else begin
						state_q <= ST_P2;
					end
				end
				ST_FT_LOAD:   if (u_done) state_q <= ST_FT_MUL_A;
				ST_FT_MUL_A:  if (u_done) state_q <= ST_FT_MUL_C1;
				ST_FT_MUL_C1: if (u_done) state_q <= ST_FT_MUL_C2;
				ST_FT_MUL_C2: if (u_done) state_q <= ST_FT_MUL_S1;
				ST_FT_MUL_S1: if (u_done) state_q <= ST_FT_MUL_S2;
				ST_FT_MUL_S2: if (u_done) state_q <= ST_FT_MUL_K;
				ST_FT_MUL_K:  if (u_done) state_q <= ST_FT_DIV;
				ST_FT_DIV: begin
					if (u_done) begin
						ta_q <= ta_val;
						if (ta_sat)
							sat_q <= 1'b1;
						state_q <= ST_FT_END;
					end
				end
				ST_FT_END: begin
					ft_q <= ft_val;
					if (tb_sat)
						sat_q <= 1'b1;
					if (ft_val == '0) begin
						empty_q <= 1'b1;
						state_q <= ST_ES_OUT;
					end else begin
						state_q <= ST_P3;
					end
				end
				ST_ES_LOAD:   if (u_done) state_q <= ST_ES_DIV;
				ST_ES_DIV:    if (u_done) state_q <= ST_ES_OUT;
				ST_ES_OUT: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_P1;
						sat_q     <= 1'b0;
						empty_q   <= 1'b0;
						first_q   <= 1'b0;
						c1_q      <= '0;
						s1_q      <= '0;
						pt_q      <= '0;
						ps_q      <= '0;
						alt_q     <= '0;
						ft_q      <= '0;
						fsamp_q   <= '0;
						fsucc_q   <= '0;
						ta_q      <= '0;
					end
				end
				default: state_q <= ST_P1;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ES_OUT && out_free)
			m_data_q <= {5'd0, total, stat, est};
	end

	assign s_tready = (state_q == ST_P1 || state_q == ST_P2 || state_q == ST_P3);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

>>> verif/tb_monte_carlo_mean_estimator.sv
`timescale 1ns / 1ps
// Self-checking testbench for monte_carlo_mean_estimator: a directed table, then random
// sample streams under several register settings, checked against a cycle-free predictor.
// Depends on mce_pkg and the monte_carlo_mean_estimator RTL.
module tb_monte_carlo_mean_estimator;
	import mce_pkg::*;

	localparam logic [63:0] CMAX      = 64'hFFFF_FFFF;
	localparam int          IDLE_MAX  = 20000;  // cycles with no handshake before giving up
	localparam int          SETTLE    = 1200;   // covers the longest divide chain
	localparam int          HOLD_LONG = 3000;

	typedef enum logic [1:0] {RUN_COUNT, RUN_PAIRS, RUN_FINAL} run_phase_t;

	typedef struct packed {
		logic [16:0] est;
		status_t     st;
		logic [31:0] total;
	} mean_t;

	// One directed item; cfg_set picks the register setting, typed rows carry the
	// result that must come out on that item.
	typedef struct packed {
		logic [1:0]  cfg_set;
		logic        smp;
		logic        typed;
		logic [16:0] est;
		status_t     st;
		logic [31:0] total;
	} row_t;

	localparam int NROWS = 14;
	localparam row_t DIRECTED [NROWS] = '{
		// No pair phase and no final phase: every run ends empty.
		'{2'd1, 1'b1, 1'b1, 17'd0, STAT_EMPTY, 32'd1},
		'{2'd1, 1'b0, 1'b0, 17'd0, STAT_OK,    32'd0},
		'{2'd1, 1'b1, 1'b1, 17'd0, STAT_EMPTY, 32'd2},
		// One pair, final target of one: estimate at its top.
		'{2'd2, 1'b1, 1'b0, 17'd0, STAT_OK,    32'd0},
		'{2'd2, 1'b1, 1'b0, 17'd0, STAT_OK,    32'd0},
		'{2'd2, 1'b0, 1'b0, 17'd0, STAT_OK,    32'd0},
		'{2'd2, 1'b1, 1'b1, 17'd65536, STAT_OK, 32'd4},
		// An equal pair gives no alternation, so phase three is empty.
		'{2'd2, 1'b1, 1'b0, 17'd0, STAT_OK,    32'd0},
		'{2'd2, 1'b1, 1'b0, 17'd0, STAT_OK,    32'd0},
		'{2'd2, 1'b1, 1'b1, 17'd0, STAT_EMPTY, 32'd3},
		// One unequal pair again, then a failure in phase three: estimate at zero.
		'{2'd2, 1'b1, 1'b0, 17'd0, STAT_OK,    32'd0},
		'{2'd2, 1'b1, 1'b0, 17'd0, STAT_OK,    32'd0},
		'{2'd2, 1'b0, 1'b0, 17'd0, STAT_OK,    32'd0},
		'{2'd2, 1'b0, 1'b1, 17'd0, STAT_OK,    32'd4}
	};

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [0] sample
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // [16:0] estimate, [18:17] status, [50:19] total_samples
	logic        cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	monte_carlo_mean_estimator uut (.*);

	always begin
		clk = 1'b1; #2;
		clk = 1'b0; #2;
	end

	// Register shadow, updated on every write the block sees.
	logic [31:0] reg_target;
	logic [47:0] reg_pair_scale;
	logic [47:0] reg_final_scale;
	logic [15:0] reg_tol;

	// Predictor state: mirrors the algorithm, one call per accepted sample.
	run_phase_t  run_ph;
	logic [63:0] cnt1, succ1, pair_goal, pair_cnt, alt_cnt, fin_goal, fin_cnt, fin_succ;
	logic        pair_first;
	logic        sat_flag;

	mean_t means_due[$];   // estimates still to come out, oldest first
	mean_t last_mean;      // result caused by the latest accepted sample, if any
	logic  last_has;
	int    n_in;           // accepted samples
	int    errors;
	int    idle_cycles;
	logic  quiet;          // no idling on either side
	logic  hold_now;       // asks the receiver for one long stall

	function automatic logic [63:0] bump(input logic [63:0] c);
		if (c >= CMAX) begin
			sat_flag = 1'b1;
			return CMAX;
		end
		return c + 64'd1;
	endfunction

	function automatic logic [63:0] clip(input logic [255:0] w);
		if (w > 256'(CMAX)) begin
			sat_flag = 1'b1;
			return CMAX;
		end
		return w[63:0];
	endfunction

	function automatic void clear_run();
		run_ph = RUN_COUNT;
		{cnt1, succ1, pair_goal, pair_cnt, alt_cnt, fin_goal, fin_cnt, fin_succ} = '0;
		pair_first = 1'b0;
		sat_flag = 1'b0;
	endfunction

	function automatic mean_t close_run(input logic empty);
		mean_t r;
		logic [63:0] sum;
		sum = cnt1 + pair_cnt + fin_cnt;
		r.total = (sum > CMAX) ? 32'hFFFF_FFFF : sum[31:0];
		r.est = empty ? 17'd0 : 17'((fin_succ << 16) / fin_goal);
		r.st = empty ? STAT_EMPTY : (sat_flag ? STAT_SAT : STAT_OK);
		clear_run();
		return r;
	endfunction

	// Final target: max of the alternation term and the tolerance floor.
	function automatic logic start_final(output mean_t r);
		logic [255:0] w;
		logic [63:0] ta, tb;
		ta = '0;
		if (pair_goal != 0) begin
			w = 256'(reg_final_scale) * 256'(alt_cnt) * 256'(cnt1) * 256'(cnt1);
			w = w / 256'd65536;
			w = w / 256'(pair_goal);
			w = w / 256'(succ1);
			w = w / 256'(succ1);
			ta = clip(w);
		end
		w = (256'(reg_final_scale) * 256'(reg_tol)) >> 32;
		tb = clip(w);
		fin_goal = (ta > tb) ? ta : tb;
		run_ph = RUN_FINAL;
		if (fin_goal == 0) begin
			r = close_run(1'b1);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Pair target is a ceiling, rounded up after each of the two divisions.
	function automatic logic start_pairs(output mean_t r);
		logic [255:0] w;
		w = 256'(reg_pair_scale) * 256'(cnt1);
		w = (w % 256'd65536 != 0) ? w / 256'd65536 + 1 : w / 256'd65536;
		w = (w % 256'(succ1) != 0) ? w / 256'(succ1) + 1 : w / 256'(succ1);
		pair_goal = clip(w);
		run_ph = RUN_PAIRS;
		if (pair_goal == 0)
			return start_final(r);
		return 1'b0;
	endfunction

	function automatic logic predict_mean(input logic smp, output mean_t r);
		logic [63:0] goal;
		logic second;
		r = '0;
		case (run_ph)
			RUN_COUNT: begin
				goal = (reg_target == 0) ? 64'd1 : 64'(reg_target);
				cnt1 = bump(cnt1);
				if (smp)
					succ1 = bump(succ1);
				if (succ1 >= goal)
					return start_pairs(r);
				return 1'b0;
			end
			RUN_PAIRS: begin
				second = pair_cnt[0];
				pair_cnt = bump(pair_cnt);
				if (!second) begin
					pair_first = smp;
					return 1'b0;
				end
				if (pair_first != smp)
					alt_cnt = bump(alt_cnt);
				if (pair_cnt >= pair_goal)
					return start_final(r);
				return 1'b0;
			end
			default: begin
				fin_cnt = bump(fin_cnt);
				if (smp)
					fin_succ = bump(fin_succ);
				if (fin_cnt >= fin_goal) begin
					r = close_run(fin_goal == 0);
					return 1'b1;
				end
				return 1'b0;
			end
		endcase
	endfunction

	// Everything is sampled at the rising edge, where inputs set at the falling edge
	// are long stable.
	always @(posedge clk or negedge arst_n) begin
		mean_t got, want;
		if (!arst_n) begin
			reg_target = SUCCESS_TARGET_RST;
			reg_pair_scale = PAIR_SCALE_RST;
			reg_final_scale = FINAL_SCALE_RST;
			reg_tol = TOLERANCE_RST;
			clear_run();
			last_has = 1'b0;
			n_in <= 0;
		end else begin
			if (cfg_we) begin
				case (reg_index_t'(cfg_index))
					REG_SUCCESS_TARGET: reg_target = cfg_data[31:0];
					REG_PAIR_SCALE:     reg_pair_scale = cfg_data;
					REG_FINAL_SCALE:    reg_final_scale = cfg_data;
					REG_TOLERANCE:      reg_tol = cfg_data[15:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				last_has = predict_mean(s_tdata[0], last_mean);
				if (last_has)
					means_due.push_back(last_mean);
				n_in <= n_in + 1;
			end
			if (m_tvalid && m_tready) begin
				got = {m_tdata[16:0], status_t'(m_tdata[18:17]), m_tdata[50:19]};
				if (means_due.size() == 0) begin
					$display("%0t: unexpected result est=%0d status=%0d total=%0d",
						$time, got.est, got.st, got.total);
					errors++;
				end else begin
					want = means_due.pop_front();
					if (got.est !== want.est) begin
						$display("%0t: estimate expected %0d actual %0d",
							$time, want.est, got.est);
						errors++;
					end
					if (got.st !== want.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.st, got.st);
						errors++;
					end
					if (got.total !== want.total) begin
						$display("%0t: total_samples expected %0d actual %0d",
							$time, want.total, got.total);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: any handshake or register write counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_MAX) begin
			$display("%0t: no progress for %0d cycles", $time, IDLE_MAX);
			$display("[monte_carlo_mean_estimator] ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold on request, none in the quiet part.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_now) begin
				m_tready = 1'b0;
				repeat (HOLD_LONG) @(negedge clk);
				hold_now = 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 9)) @(negedge clk);
			end
			m_tready = 1'b1;
		end
	end

	task automatic write_reg(input reg_index_t idx, input logic [47:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(input logic [31:0] tgt, input logic [47:0] ps,
			input logic [47:0] fs, input logic [15:0] tol);
		write_reg(REG_SUCCESS_TARGET, 48'(tgt));
		write_reg(REG_PAIR_SCALE, ps);
		write_reg(REG_FINAL_SCALE, fs);
		write_reg(REG_TOLERANCE, 48'(tol));
	endtask

	// Offers one sample, sometimes after a random gap, and returns once it is taken.
	// Upper tdata bits are junk the block must ignore.
	task automatic send_sample(input logic smp);
		int want_n;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {7'($urandom), smp};
		want_n = n_in + 1;
		do @(negedge clk); while (n_in != want_n);
		s_tvalid = 1'b0;
	endtask

	// Lets every result arrive, then covers a divide chain that yields nothing.
	task automatic settle();
		s_tvalid = 1'b0;
		wait (means_due.size() == 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// Random samples in short runs of a fixed success rate. Rates stay away from
	// zero so that the derived targets stay small.
	task automatic random_samples(input int count);
		int rate, left;
		left = 0;
		rate = 50;
		repeat (count) begin
			if (left == 0) begin
				rate = $urandom_range(20, 80);
				left = $urandom_range(10, 60);
			end
			left--;
			send_sample($urandom_range(0, 99) < rate);
		end
	endtask

	initial begin
		logic [1:0] cur_set;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 1'b0;
		hold_now = 1'b0;
		errors = 0;
		idle_cycles = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table; the predictor must agree with every typed result.
		cur_set = 2'd0;
		for (int i = 0; i < NROWS; i++) begin
			if (DIRECTED[i].cfg_set != cur_set) begin
				settle();
				cur_set = DIRECTED[i].cfg_set;
				if (cur_set == 2'd1)
					write_all(32'd1, 48'd0, 48'd0, 16'hFFFF);
				else
					write_all(32'd1, 48'd65536, 48'd65536, 16'hFFFF);
			end
			send_sample(DIRECTED[i].smp);
			if (DIRECTED[i].typed !== last_has ||
					(last_has && last_mean !== {DIRECTED[i].est, DIRECTED[i].st,
					DIRECTED[i].total})) begin
				$display("%0t: row %0d expected est=%0d status=%0d total=%0d actual %0d/%0d/%0d",
					$time, i, DIRECTED[i].est, DIRECTED[i].st, DIRECTED[i].total,
					last_mean.est, last_mean.st, last_mean.total);
				errors++;
			end
		end
		settle();

		// Every register bit high, then replaced before any sample arrives.
		write_all(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 16'hFFFF);

		write_all(32'd5, 48'd65536, 48'd131072, 16'd6554);
		hold_now = 1'b1;   // outputs back up and the sample input stalls
		random_samples(205);
		settle();

		// A target of zero acts as one.
		write_all(32'd0, 48'd131072, 48'd262144, 16'hFFFF);
		random_samples(205);
		settle();

		write_all(32'd20, 48'd32768, 48'd524288, 16'd1);
		random_samples(205);
		settle();

		// No pair phase; the tolerance floor alone sets the final target.
		write_all(32'd3, 48'd0, 48'd131072, 16'd32768);
		random_samples(205);
		settle();

		quiet = 1'b1;
		write_all(32'd10, 48'd196608, 48'd65536, 16'd6554);
		random_samples(205);
		settle();

		if (errors == 0)
			$display("[monte_carlo_mean_estimator] OK");
		else
			$display("[monte_carlo_mean_estimator] ERROR");
		$finish;
	end

endmodule
